/* design/chm_pkg.sv */
`timescale 1ns / 1ps
package chm_pkg;
  localparam int unsigned DefBuckets = 256;
  localparam int unsigned DefEntries = 1024;
  localparam int unsigned DefKeyBits = 32;
  localparam int unsigned DefValueBits = 32;
  localparam int unsigned DefMaxMatches = 64;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_CONTAINS = 2'd1,
    OP_FIND     = 2'd2,
    OP_FIND_ALL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;
endpackage

/* design/chm_ram.sv */
`timescale 1ns / 1ps
module chm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* design/chained_hash_multimap_core.sv */
`timescale 1ns / 1ps
// Hash-join build/probe table. Key low bits select a bucket; each bucket holds
// a chain in insertion order stored in synchronous RAMs. An insert goes through
// accept, bucket read, bucket/entry/link write and result. A probe of a used
// bucket walks its chain (one entry-RAM read and one compare per step), and a
// find-all probe also emits each match; a stalled result holds the core.
// Find-all emits up to MAX_MATCHES results, flagging truncation on the last.
// After reset, the bucket-used bits are cleared before the first transaction
// is accepted.
module chained_hash_multimap_core
  import chm_pkg::*;
#(
  parameter int unsigned BUCKETS     = DefBuckets,
  parameter int unsigned ENTRIES     = DefEntries,
  parameter int unsigned KEY_BITS    = DefKeyBits,
  parameter int unsigned VALUE_BITS  = DefValueBits,
  parameter int unsigned MAX_MATCHES = DefMaxMatches
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [31:0] key,
  input  logic [31:0] item_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [31:0] match_value,
  output logic        last,
  output logic [1:0]  status,
  output logic [10:0] entry_count
);
  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned EW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned MW = $clog2(MAX_MATCHES + 1);
  // bucket word: used, head, tail
  localparam int unsigned BKW = 1 + 2 * EW;
  localparam int unsigned ENW = KEY_BITS + VALUE_BITS;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_BRD   = 8'b00000100,
    S_BCHK  = 8'b00001000,
    S_ERD   = 8'b00010000,
    S_ECHK  = 8'b00100000,
    S_EMIT  = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t              state;
  logic [1:0]          op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [CW-1:0]       count;
  logic [BW-1:0]       clr_addr;
  logic [EW-1:0]       cur, tail_r;
  logic [MW-1:0]       nmatch;

  // bucket ram
  logic           b_we;
  logic [BW-1:0]  b_waddr, b_raddr;
  logic [BKW-1:0] b_wdata, b_rdata;
  // entry ram (key, value) and separate link ram for next pointers
  logic           e_we;
  logic [EW-1:0]  e_waddr, e_raddr;
  logic [ENW-1:0] e_wdata, e_rdata;

  logic [KEY_BITS-1:0]   key_in;
  logic [VALUE_BITS-1:0] val_in;
  logic [BW-1:0]         bidx;
  logic                  bu;
  logic [EW-1:0]         bhead, btail;
  logic [KEY_BITS-1:0]   ekey;
  logic [VALUE_BITS-1:0] eval;

  logic          o_valid, o_found;
  logic          o_valid_next;
  logic [31:0]   o_val;
  logic [1:0]    o_status;
  logic          emit_ok;

  assign key_in = KEY_BITS'(key);
  assign val_in = VALUE_BITS'(item_value);
  assign bidx   = BW'(key_r);
  assign {bu, bhead, btail} = b_rdata;
  assign {ekey, eval} = e_rdata;

  assign in_stall = (state != S_IDLE);
  assign emit_ok  = !o_valid || !out_stall;

  chm_ram #(.WIDTH(BKW), .DEPTH(BUCKETS)) u_bucket (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  chm_ram #(.WIDTH(ENW), .DEPTH(ENTRIES)) u_entry (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  // links sit in their own ram so a tail link is a single write
  logic           l_we;
  logic [EW-1:0]  l_waddr, l_raddr;
  logic [EW-1:0]  l_wdata, l_rdata;

  chm_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_link (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  always_comb begin
    b_we    = 1'b0;
    b_waddr = bidx;
    b_wdata = '0;
    b_raddr = bidx;
    e_we    = 1'b0;
    e_waddr = count[EW-1:0];
    e_wdata = {key_r, val_r};
    e_raddr = cur;
    l_we    = 1'b0;
    l_waddr = btail;
    l_wdata = count[EW-1:0];
    l_raddr = cur;
    if (state == S_CLEAR) begin
      b_we    = 1'b1;
      b_waddr = clr_addr;
    end
    if (state == S_BCHK && op_r == OP_INSERT && count < CW'(ENTRIES)) begin
      b_we    = 1'b1;
      b_wdata = {1'b1, (bu ? bhead : count[EW-1:0]), count[EW-1:0]};
      e_we    = 1'b1;
      l_we    = bu;
    end
    if (state == S_BCHK) begin
      e_raddr = bhead;
      l_raddr = bhead;
    end
  end

  always_comb begin
    o_valid_next = o_valid && out_stall;
    if (state == S_EMIT && emit_ok && nmatch != '0) o_valid_next = 1'b1;
    if (state == S_DONE && emit_ok) o_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      count    <= '0;
      nmatch   <= '0;
      o_valid  <= 1'b0;
    end else begin
      o_valid <= o_valid_next;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == BW'(BUCKETS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r   <= op;
            key_r  <= key_in;
            val_r  <= val_in;
            nmatch <= '0;
            state  <= S_BRD;
          end
        end
        S_BRD: state <= S_BCHK;
        S_BCHK: begin
          cur      <= bhead;
          tail_r   <= btail;
          o_val    <= '0;
          o_found  <= (op_r == OP_INSERT) && (count < CW'(ENTRIES));
          o_status <= (op_r == OP_INSERT && count >= CW'(ENTRIES)) ? ST_FULL : ST_OK;
          if (op_r == OP_INSERT) begin
            if (count < CW'(ENTRIES)) count <= count + 1'b1;
            state <= S_DONE;
          end else if (bu) begin
            state <= S_ECHK;
          end else begin
            state <= S_DONE;
          end
        end
        S_ERD: state <= S_ECHK;
        S_ECHK: begin
          if (ekey == key_r) begin
            if (op_r != OP_FIND_ALL) begin
              o_found <= 1'b1;
              o_val   <= (op_r == OP_FIND) ? 32'(eval) : '0;
              state   <= S_DONE;
            end else if (nmatch == MW'(MAX_MATCHES)) begin
              // previous emitted one is held back as last
              o_status <= ST_TRUNCATED;
              state    <= S_DONE;
            end else begin
              state <= S_EMIT;
            end
          end else if (cur == tail_r) begin
            state <= S_DONE;
          end else begin
            cur   <= l_rdata;
            state <= S_ERD;
          end
        end
        S_EMIT: begin
          // one pending match is held in pend_val until the next is known
          if (emit_ok) begin
            nmatch  <= nmatch + 1'b1;
            if (cur == tail_r) begin
              state <= S_DONE;
            end else begin
              cur   <= l_rdata;
              state <= S_ERD;
            end
          end
        end
        S_DONE: begin
          if (emit_ok) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // pending-match holding register for find-all
  logic [31:0] pend_val;
  logic        pend_ok;
  always_ff @(posedge clk) begin
    if (state == S_EMIT && emit_ok) begin
      pend_val <= 32'(eval);
    end
  end
  assign pend_ok = (op_r == OP_FIND_ALL) && (nmatch != '0);

  // outputs: in find-all the emitted word is the pending match
  logic [31:0] out_val_r;
  logic        out_found_r, out_last_r;
  logic [1:0]  out_status_r;
  logic [10:0] out_count_r;
  always_ff @(posedge clk) begin
    if (state == S_EMIT && emit_ok && nmatch != '0) begin
      out_val_r    <= pend_val;
      out_found_r  <= 1'b1;
      out_last_r   <= 1'b0;
      out_status_r <= ST_OK;
      out_count_r  <= 11'(count);
    end else if (state == S_DONE && emit_ok) begin
      out_val_r    <= pend_ok ? pend_val : o_val;
      out_found_r  <= pend_ok ? 1'b1 : o_found;
      out_last_r   <= 1'b1;
      out_status_r <= o_status;
      out_count_r  <= 11'(count);
    end
  end

  assign out_valid   = o_valid;
  assign found       = out_found_r;
  assign match_value = out_val_r;
  assign last        = out_last_r;
  assign status      = out_status_r;
  assign entry_count = out_count_r;

  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= CW'(ENTRIES))
    else $error("entry count overflow");
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accepted while busy");
  a_match_cap: assert property (@(posedge clk) disable iff (rst)
    nmatch <= MW'(MAX_MATCHES)) else $error("too many matches");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (o_valid && out_stall) |=> o_valid) else $error("result dropped");
endmodule

/* verif/chained_hash_multimap_core_tb.sv */
`timescale 1ns / 1ps
module chained_hash_multimap_core_tb;
  import chm_pkg::*;

  localparam int unsigned NumEntries = DefEntries;
  localparam int unsigned MaxMatches = DefMaxMatches;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    op_t         op;
    logic [31:0] key;
    logic [31:0] value;
  } probe_t;

  typedef struct packed {
    logic        found;
    logic [31:0] match_value;
    logic        last;
    status_t     status;
    logic [10:0] entry_count;
  } answer_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  op;
  logic [31:0] key;
  logic [31:0] item_value;
  logic        out_valid;
  logic        out_stall;
  logic        found;
  logic [31:0] match_value;
  logic        last;
  logic [1:0]  status;
  logic [10:0] entry_count;

  chained_hash_multimap_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .key(key), .item_value(item_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .match_value(match_value), .last(last),
    .status(status), .entry_count(entry_count)
  );

  // shadow table: flat list of entries in insertion order
  logic [31:0] shadow_key[$];
  logic [31:0] shadow_value[$];

  probe_t  pending_probes[$];
  answer_t expected_answers[$];

  int unsigned mismatches = 0;
  int unsigned idle_cycles;
  bit          quiet_phase;
  int unsigned in_gap;
  int unsigned out_gap;

  // walk the entries in insertion order, which matches per-bucket chain order
  task automatic predict_answers(input probe_t p);
    answer_t a;
    int n;
    bit hit;
    bit trunc;
    logic [31:0] first_val;
    n = 0;
    hit = 0;
    trunc = 0;
    first_val = '0;
    if (p.op == OP_INSERT) begin
      if (shadow_key.size() >= NumEntries) begin
        a = '{1'b0, 32'd0, 1'b1, ST_FULL, 11'(shadow_key.size())};
      end else begin
        shadow_key = {shadow_key, p.key};
        shadow_value = {shadow_value, p.value};
        a = '{1'b1, 32'd0, 1'b1, ST_OK, 11'(shadow_key.size())};
      end
      expected_answers = {expected_answers, a};
      return;
    end
    foreach (shadow_key[i]) begin
      if (shadow_key[i] == p.key) begin
        if (!hit) first_val = shadow_value[i];
        hit = 1;
        if (p.op != OP_FIND_ALL) break;
        if (n < MaxMatches) begin
          a = '{1'b1, shadow_value[i], 1'b0, ST_OK, 11'(shadow_key.size())};
          expected_answers = {expected_answers, a};
          n++;
        end else begin
          trunc = 1;
          break;
        end
      end
    end
    if (p.op == OP_CONTAINS) begin
      a = '{hit, 32'd0, 1'b1, ST_OK, 11'(shadow_key.size())};
      expected_answers = {expected_answers, a};
    end else if (p.op == OP_FIND) begin
      a = '{hit, hit ? first_val : 32'd0, 1'b1, ST_OK, 11'(shadow_key.size())};
      expected_answers = {expected_answers, a};
    end else if (n == 0) begin
      a = '{1'b0, 32'd0, 1'b1, ST_OK, 11'(shadow_key.size())};
      expected_answers = {expected_answers, a};
    end else begin
      a = expected_answers.pop_back();
      a.last = 1'b1;
      if (trunc) a.status = ST_TRUNCATED;
      expected_answers = {expected_answers, a};
    end
  endtask

  function automatic logic [31:0] rand_key(input logic [31:0] pool[$]);
    if (pool.size() > 0 && $urandom_range(0, 3) != 0)
      return pool[$urandom_range(0, pool.size() - 1)];
    return $urandom();
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      op <= OP_INSERT;
      key <= '0;
      item_value <= '0;
      in_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_answers('{op_t'(op), key, item_value});
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_probes.size() > 0) begin
        probe_t p;
        p = pending_probes.pop_front();
        in_valid <= 1'b1;
        op <= p.op;
        key <= p.key;
        item_value <= p.value;
        if (!quiet_phase && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 16);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall and result check
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: found=%0b val=%h", found,
                                         match_value);
        end else begin
          answer_t e;
          e = expected_answers.pop_front();
          if (found !== e.found || match_value !== e.match_value || last !== e.last ||
              status !== e.status || entry_count !== e.entry_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp f=%0b v=%h l=%0b s=%0d c=%0d got f=%0b v=%h l=%0b s=%0d c=%0d",
                       e.found, e.match_value, e.last, e.status, e.entry_count,
                       found, match_value, last, status, entry_count);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic add_probe(input op_t o, input logic [31:0] k, input logic [31:0] v);
    probe_t p;
    p = '{o, k, v};
    pending_probes = {pending_probes, p};
  endtask

  initial begin
    logic [31:0] keys[$];
    logic [31:0] k;
    rst = 1'b1;
    quiet_phase = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: misses on an empty table, extremes, collisions, truncation
    add_probe(OP_CONTAINS, 32'd0, 32'd0);
    add_probe(OP_FIND, 32'hFFFF_FFFF, 32'd0);
    add_probe(OP_FIND_ALL, 32'd5, 32'hFFFF_FFFF);
    add_probe(OP_INSERT, 32'd0, 32'hFFFF_FFFF);
    add_probe(OP_INSERT, 32'hFFFF_FFFF, 32'd0);
    add_probe(OP_INSERT, 32'h0000_0100, 32'hA5A5_5A5A);  // same bucket as key 0
    add_probe(OP_INSERT, 32'd0, 32'h5A5A_A5A5);
    add_probe(OP_CONTAINS, 32'h0000_0100, 32'd7);
    add_probe(OP_FIND, 32'd0, 32'd0);
    add_probe(OP_FIND, 32'h0000_0200, 32'd0);            // bucket used, key absent
    add_probe(OP_FIND_ALL, 32'd0, 32'd0);
    add_probe(OP_FIND_ALL, 32'hFFFF_FFFF, 32'd0);
    for (int i = 0; i < MaxMatches + 3; i++) add_probe(OP_INSERT, 32'h0000_1234, 32'(i));
    add_probe(OP_FIND_ALL, 32'h0000_1234, 32'd0);
    add_probe(OP_FIND, 32'h0000_1234, 32'd0);
    keys = '{32'd0, 32'hFFFF_FFFF, 32'h100, 32'h1234};

    // random: mostly probes of keys already stored, some in shared buckets
    for (int i = 0; i < 66; i++) begin
      case ($urandom_range(0, 4))
        0, 1: begin
          k = ($urandom_range(0, 1) != 0) ? rand_key(keys)
                                          : ((32'($urandom_range(0, 3)) << 8) | 32'h44);
          keys = {keys, k};
          add_probe(OP_INSERT, k, $urandom());
        end
        2: add_probe(OP_CONTAINS, rand_key(keys), $urandom());
        3: add_probe(OP_FIND, rand_key(keys), $urandom());
        default: add_probe(OP_FIND_ALL, rand_key(keys), $urandom());
      endcase
    end

    add_probe(OP_INSERT, 32'hDEAD_BEEF, 32'h1);
    add_probe(OP_FIND_ALL, 32'h0000_1234, 32'd0);
    add_probe(OP_CONTAINS, 32'hDEAD_BEEF, 32'd0);

    wait (pending_probes.size() < 60);
    quiet_phase = 1;
    wait (pending_probes.size() == 0 && !in_valid);
    wait (expected_answers.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
